// File: hdl/adpu_pkg.sv
// ============================================================================
// adpu_pkg
// shared types and encodings of the data-processing execute unit
// ============================================================================
package adpu_pkg;

    localparam int unsigned WordBits = 32;
    localparam int unsigned RegCount = 16;

    typedef logic [WordBits-1:0] t_word;
    typedef logic [3:0]          t_reg_idx;
    typedef logic [3:0]          t_opcode;
    typedef logic [1:0]          t_shift_kind;

    // supported opcodes
    localparam t_opcode OP_AND = 4'd0;
    localparam t_opcode OP_EOR = 4'd1;
    localparam t_opcode OP_SUB = 4'd2;
    localparam t_opcode OP_RSB = 4'd3;
    localparam t_opcode OP_ADD = 4'd4;
    localparam t_opcode OP_TST = 4'd8;
    localparam t_opcode OP_TEQ = 4'd9;
    localparam t_opcode OP_CMP = 4'd10;
    localparam t_opcode OP_ORR = 4'd12;
    localparam t_opcode OP_MOV = 4'd13;

    // shifter kinds
    localparam t_shift_kind SH_LSL = 2'd0;
    localparam t_shift_kind SH_LSR = 2'd1;
    localparam t_shift_kind SH_ASR = 2'd2;
    localparam t_shift_kind SH_ROR = 2'd3;

endpackage

// File: hdl/adpu_if.sv
// ============================================================================
// adpu channel interfaces
// valid/ready channels for instruction requests and execute results
// ============================================================================
interface adpu_in_if;
    logic           valid;
    logic           ready;
    adpu_pkg::t_word instr;

    modport source (output valid, output instr, input ready);
    modport sink   (input valid, input instr, output ready);
endinterface

interface adpu_out_if;
    logic              valid;
    logic              ready;
    adpu_pkg::t_word    result_value;
    adpu_pkg::t_reg_idx dest_reg;
    logic              reg_written;
    logic              flag_n;
    logic              flag_z;
    logic              flag_c;
    logic              bad_opcode;

    modport source (output valid, output result_value, output dest_reg,
                    output reg_written, output flag_n, output flag_z,
                    output flag_c, output bad_opcode, input ready);
    modport sink   (input valid, input result_value, input dest_reg,
                    input reg_written, input flag_n, input flag_z,
                    input flag_c, input bad_opcode, output ready);
endinterface

// File: hdl/arm_data_processing_unit_core.sv
// ============================================================================
// arm_data_processing_unit_core
// datapath: an accepted request is registered into execute, and its result is
//   registered into the output register when execute hands it on
// throughput: one request per cycle while the output register is empty or being
//   read; execute writes back at the same edge that its result is registered
// reset: synchronous, clears flags, register valid bits (registers read as
//   zero until written) and the pipeline valids; no clearing pass is needed
// ============================================================================
module arm_data_processing_unit_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    adpu_in_if.sink      i_in,
    adpu_out_if.source   o_out
);

    // ------------------------------------------------------------------
    // handshake control
    // ------------------------------------------------------------------
    logic r_s1_vld;     // an instruction sits in execute
    logic r_out_vld;    // a result waits in the output register
    logic s1_move;      // execute commits and hands its result on
    logic in_acc;       // request accepted this cycle

    assign s1_move     = r_s1_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_s1_vld || s1_move;
    assign in_acc      = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // register file: two copies of the same contents, each one memory.
    // copy a serves Rn and Rm, copy b serves Rs. both are written together.
    // ------------------------------------------------------------------
    adpu_pkg::t_word r_mem_a [adpu_pkg::RegCount];
    adpu_pkg::t_word r_mem_b [adpu_pkg::RegCount];
    logic [adpu_pkg::RegCount-1:0] r_rf_vld;   // entry written since reset

    adpu_pkg::t_word r_instr;
    adpu_pkg::t_word r_rn_q, r_rm_q, r_rs_q;
    logic            r_rn_vq, r_rm_vq, r_rs_vq;

    // write that commits at the same edge a request is accepted; the read
    // issued at that edge misses it, so it is forwarded into execute
    logic               r_byp_vld;
    adpu_pkg::t_reg_idx r_byp_idx;
    adpu_pkg::t_word    r_byp_data;

    // execute results
    adpu_pkg::t_word exe_res;
    logic            exe_wr;
    logic            exe_ok;
    logic            n_flag_n, n_flag_z, n_flag_c;

    // flag registers
    logic r_flag_n, r_flag_z, r_flag_c;

    // read side: addresses come straight from the incoming request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_instr <= i_in.instr;
            r_rn_q  <= r_mem_a[i_in.instr[19:16]];
            r_rm_q  <= r_mem_a[i_in.instr[3:0]];
            r_rs_q  <= r_mem_b[i_in.instr[11:8]];
            r_rn_vq <= r_rf_vld[i_in.instr[19:16]];
            r_rm_vq <= r_rf_vld[i_in.instr[3:0]];
            r_rs_vq <= r_rf_vld[i_in.instr[11:8]];
        end
    end

    // write side: execute commits when it hands the result on
    always_ff @(posedge i_clk) begin
        if (s1_move && exe_wr) begin
            r_mem_a[r_instr[15:12]] <= exe_res;
            r_mem_b[r_instr[15:12]] <= exe_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_byp_vld <= 1'b0;
        end else begin
            if (s1_move && exe_wr) begin
                r_rf_vld[r_instr[15:12]] <= 1'b1;
            end
            if (in_acc) begin
                r_byp_vld <= s1_move && exe_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byp_idx  <= r_instr[15:12];
            r_byp_data <= exe_res;
        end
    end

    // ------------------------------------------------------------------
    // operand fetch with forwarding; unwritten registers read as zero
    // ------------------------------------------------------------------
    adpu_pkg::t_word rn_val, rm_val, rs_val;

    always_comb begin
        rn_val = r_rn_vq ? r_rn_q : '0;
        rm_val = r_rm_vq ? r_rm_q : '0;
        rs_val = r_rs_vq ? r_rs_q : '0;
        if (r_byp_vld && (r_byp_idx == r_instr[19:16])) begin
            rn_val = r_byp_data;
        end
        if (r_byp_vld && (r_byp_idx == r_instr[3:0])) begin
            rm_val = r_byp_data;
        end
        if (r_byp_vld && (r_byp_idx == r_instr[11:8])) begin
            rs_val = r_byp_data;
        end
    end

    // ------------------------------------------------------------------
    // operand 2: rotated immediate or barrel shifter
    // ------------------------------------------------------------------
    logic [7:0]      sh_amt;
    logic [4:0]      sh_lo;
    logic            sh_big;     // amount of 32 or more
    logic [32:0]     lsl_t, lsr_t, asr_t;
    logic [63:0]     ror_t, imm_t;
    adpu_pkg::t_word op2;
    logic            sh_c;

    assign sh_amt = r_instr[4] ? rs_val[7:0] : {3'b000, r_instr[11:7]};
    assign sh_lo  = sh_amt[4:0];
    assign sh_big = (sh_amt[7:5] != 3'b000);
    assign lsl_t  = {1'b0, rm_val} << sh_lo;
    assign lsr_t  = {rm_val, 1'b0} >> sh_lo;
    assign asr_t  = 33'($signed({rm_val, 1'b0}) >>> sh_lo);
    assign ror_t  = {rm_val, rm_val} >> sh_lo;
    assign imm_t  = {24'd0, r_instr[7:0], 24'd0, r_instr[7:0]} >> {r_instr[11:8], 1'b0};

    always_comb begin
        op2  = rm_val;
        sh_c = r_flag_c;
        if (r_instr[25]) begin
            // rotated immediate leaves the carry alone
            op2 = imm_t[31:0];
        end else if (sh_amt != 8'd0) begin
            case (r_instr[6:5])
                adpu_pkg::SH_LSL: begin
                    if (sh_big) begin
                        op2  = '0;
                        sh_c = (sh_amt == 8'd32) ? rm_val[0] : 1'b0;
                    end else begin
                        op2  = lsl_t[31:0];
                        sh_c = lsl_t[32];
                    end
                end
                adpu_pkg::SH_LSR: begin
                    if (sh_big) begin
                        op2  = '0;
                        sh_c = (sh_amt == 8'd32) ? rm_val[31] : 1'b0;
                    end else begin
                        op2  = lsr_t[32:1];
                        sh_c = lsr_t[0];
                    end
                end
                adpu_pkg::SH_ASR: begin
                    if (sh_big) begin
                        op2  = {32{rm_val[31]}};
                        sh_c = rm_val[31];
                    end else begin
                        op2  = asr_t[32:1];
                        sh_c = asr_t[0];
                    end
                end
                default: begin
                    // rotate: carry is the bit that lands on top
                    op2  = ror_t[31:0];
                    sh_c = ror_t[31];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // alu: one shared 33-bit adder for add, sub, rsb and cmp
    // ------------------------------------------------------------------
    adpu_pkg::t_word add_x, add_y;
    logic            add_cin;
    logic [32:0]     add_sum;
    logic            arith;

    always_comb begin
        add_x   = rn_val;
        add_y   = op2;
        add_cin = 1'b0;
        case (r_instr[24:21])
            adpu_pkg::OP_SUB, adpu_pkg::OP_CMP: begin
                add_y   = ~op2;
                add_cin = 1'b1;
            end
            adpu_pkg::OP_RSB: begin
                add_x   = op2;
                add_y   = ~rn_val;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};

    always_comb begin
        exe_res = '0;
        exe_wr  = 1'b1;
        exe_ok  = 1'b1;
        arith   = 1'b0;
        case (r_instr[24:21])
            adpu_pkg::OP_AND: exe_res = rn_val & op2;
            adpu_pkg::OP_EOR: exe_res = rn_val ^ op2;
            adpu_pkg::OP_SUB, adpu_pkg::OP_RSB, adpu_pkg::OP_ADD: begin
                exe_res = add_sum[31:0];
                arith   = 1'b1;
            end
            adpu_pkg::OP_TST: begin
                exe_res = rn_val & op2;
                exe_wr  = 1'b0;
            end
            adpu_pkg::OP_TEQ: begin
                exe_res = rn_val ^ op2;
                exe_wr  = 1'b0;
            end
            adpu_pkg::OP_CMP: begin
                exe_res = add_sum[31:0];
                arith   = 1'b1;
                exe_wr  = 1'b0;
            end
            adpu_pkg::OP_ORR: exe_res = rn_val | op2;
            adpu_pkg::OP_MOV: exe_res = op2;
            default: begin
                // unsupported opcode: no register write and no flag change
                exe_ok  = 1'b0;
                exe_wr  = 1'b0;
                exe_res = '0;
            end
        endcase
    end

    // flags follow the alu only with the s bit on a supported opcode
    logic flag_upd;
    assign flag_upd = exe_ok && r_instr[20];

    always_comb begin
        n_flag_n = r_flag_n;
        n_flag_z = r_flag_z;
        n_flag_c = r_flag_c;
        if (flag_upd) begin
            n_flag_n = exe_res[31];
            n_flag_z = (exe_res == '0);
            n_flag_c = arith ? add_sum[32] : sh_c;
        end
    end

    // ------------------------------------------------------------------
    // pipeline valids, flags and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_flag_n  <= 1'b0;
            r_flag_z  <= 1'b0;
            r_flag_c  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
                r_flag_n  <= n_flag_n;
                r_flag_z  <= n_flag_z;
                r_flag_c  <= n_flag_c;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    adpu_pkg::t_word    r_o_res;
    adpu_pkg::t_reg_idx r_o_rd;
    logic               r_o_wr, r_o_n, r_o_z, r_o_c, r_o_bad;

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_res <= exe_res;
            r_o_rd  <= r_instr[15:12];
            r_o_wr  <= exe_wr;
            r_o_n   <= n_flag_n;
            r_o_z   <= n_flag_z;
            r_o_c   <= n_flag_c;
            r_o_bad <= !exe_ok;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result_value = r_o_res;
    assign o_out.dest_reg     = r_o_rd;
    assign o_out.reg_written  = r_o_wr;
    assign o_out.flag_n       = r_o_n;
    assign o_out.flag_z       = r_o_z;
    assign o_out.flag_c       = r_o_c;
    assign o_out.bad_opcode   = r_o_bad;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_opcode |-> !o_out.reg_written && (o_out.result_value == '0))
        else $error("unsupported opcode reported a write or a value");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s1_move && flag_upd) |=> $stable({r_flag_n, r_flag_z, r_flag_c}))
        else $error("flags changed without an s-bit commit");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && exe_wr |=> r_rf_vld[$past(r_instr[15:12])])
        else $error("committed write left register unmarked");

    a_stall_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_out_vld && !o_out.ready |=> r_s1_vld && $stable(r_instr))
        else $error("stalled instruction lost in execute");

endmodule
